// ===== sv/batched_spsc_ring_queue_top_assert.svh =====
// Assertion macros for the batched SPSC ring queue.
// Used by brq_ctrl, the only module that carries concurrent checks; needs no other file.
`ifndef BATCHED_SPSC_RING_QUEUE_TOP_ASSERT_SVH
`define BATCHED_SPSC_RING_QUEUE_TOP_ASSERT_SVH

// same-cycle implication under asynchronous active-low reset
`define BRQ_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define BRQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/brq_pkg.sv =====
// Shared types and constants for the batched SPSC ring queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brq_pkg;

	localparam int DATA_W = 64;
	localparam int KIND_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_PRODUCE = 2'd0,
		KIND_CONSUME = 2'd1,
		KIND_FLUSH   = 2'd2
	} brq_kind_t;

	typedef struct packed {
		logic ok;
		logic rd;
	} brq_status_t;

endpackage

`default_nettype wire

// ===== sv/brq_if.sv =====
// Valid/ready channel interfaces for requests and responses of the ring queue.
// Depends on brq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface brq_req_if import brq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [DATA_W-1:0] data_in;

	modport source (output valid, output kind, output data_in, input ready);
	modport sink (input valid, input kind, input data_in, output ready);
endinterface

interface brq_rsp_if import brq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              ok;
	logic [DATA_W-1:0] data_out;

	modport source (output valid, output ok, output data_out, input ready);
	modport sink (input valid, input ok, input data_out, output ready);
endinterface

`default_nettype wire

// ===== sv/brq_ram.sv =====
// Slot storage: one write port, one read port, registered read data.
// Depends on brq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brq_ram import brq_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] slots_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			slots_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= slots_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/brq_ctrl.sv =====
// Index, cache and batch-count control for the ring queue; drives slot RAM access.
// Depends on brq_pkg and batched_spsc_ring_queue_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "batched_spsc_ring_queue_top_assert.svh"

module brq_ctrl import brq_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int BATCH = 8,
	parameter int AW    = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [KIND_W-1:0] kind,
	output brq_status_t            status,
	output logic                   mem_we,
	output logic      [AW-1:0]     mem_waddr,
	output logic                   mem_re,
	output logic      [AW-1:0]     mem_raddr
);

	localparam int BW = $clog2(BATCH + 1);

	logic [AW-1:0] wi_q, cri_q, pwi_q, ri_q, cwi_q, pri_q;
	logic [AW-1:0] wi_d, cri_d, pwi_d, ri_d, cwi_d, pri_d;
	logic [BW-1:0] wbc_q, rbc_q, wbc_d, rbc_d;
	logic [AW-1:0] w_after, r_after;
	logic [BW-1:0] wbc_inc, rbc_inc;
	logic          full_cached, full, empty_cached, empty;
	logic          prod_ok, cons_ok;

	function automatic logic [AW-1:0] adv(input logic [AW-1:0] x);
		adv = (x == AW'(DEPTH - 1)) ? '0 : x + 1'b1;
	endfunction

	assign w_after      = adv(wi_q);
	assign r_after      = adv(ri_q);
	assign wbc_inc      = wbc_q + 1'b1;
	assign rbc_inc      = rbc_q + 1'b1;
	assign full_cached  = (w_after == cri_q);
	assign full         = full_cached && (w_after == pri_q);
	assign empty_cached = (ri_q == cwi_q);
	assign empty        = empty_cached && (ri_q == pwi_q);

	assign prod_ok = accept && (kind == KIND_PRODUCE) && status.ok;
	assign cons_ok = accept && (kind == KIND_CONSUME) && status.ok;

	assign mem_waddr = wi_q;
	assign mem_raddr = ri_q;

	always_comb begin
		wi_d      = wi_q;
		cri_d     = cri_q;
		pwi_d     = pwi_q;
		wbc_d     = wbc_q;
		ri_d      = ri_q;
		cwi_d     = cwi_q;
		pri_d     = pri_q;
		rbc_d     = rbc_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		status.ok = 1'b0;
		status.rd = 1'b0;
		case (kind)
			KIND_PRODUCE: begin
				status.ok = !full;
				if (accept && !full) begin
					mem_we = 1'b1;
					wi_d   = w_after;
					if (full_cached) begin
						cri_d = pri_q;
					end
					if (wbc_inc == BW'(BATCH)) begin
						pwi_d = w_after;
						wbc_d = '0;
					end else begin
						wbc_d = wbc_inc;
					end
				end
			end
			KIND_CONSUME: begin
				status.ok = !empty;
				status.rd = !empty;
				if (accept && !empty) begin
					mem_re = 1'b1;
					ri_d   = r_after;
					if (empty_cached) begin
						cwi_d = pwi_q;
					end
					if (rbc_inc == BW'(BATCH)) begin
						pri_d = r_after;
						rbc_d = '0;
					end else begin
						rbc_d = rbc_inc;
					end
				end
			end
			KIND_FLUSH: begin
				status.ok = 1'b1;
				if (accept) begin
					pwi_d = wi_q;
					wbc_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q  <= '0;
			cri_q <= '0;
			pwi_q <= '0;
			wbc_q <= '0;
			ri_q  <= '0;
			cwi_q <= '0;
			pri_q <= '0;
			rbc_q <= '0;
		end else begin
			wi_q  <= wi_d;
			cri_q <= cri_d;
			pwi_q <= pwi_d;
			wbc_q <= wbc_d;
			ri_q  <= ri_d;
			cwi_q <= cwi_d;
			pri_q <= pri_d;
			rbc_q <= rbc_d;
		end
	end

	`BRQ_ASSERT_NOW(a_wbc_range, clk, arst_n, 1'b1, wbc_q < BW'(BATCH), "write batch overrun")
	`BRQ_ASSERT_NOW(a_rbc_range, clk, arst_n, 1'b1, rbc_q < BW'(BATCH), "read batch overrun")
	`BRQ_ASSERT_NEXT(a_keep_gap, clk, arst_n, prod_ok, wi_q != cri_q, "produce closed the gap")
	`BRQ_ASSERT_NOW(a_read_bound, clk, arst_n, cons_ok, ri_q != pwi_q, "read past write index")

endmodule

`default_nettype wire

// ===== sv/batched_spsc_ring_queue_top.sv =====
// Top level of the batched SPSC ring queue: handshake, response register, RAM and control.
// Depends on brq_pkg, brq_if, brq_ram and brq_ctrl.
//
//   channel | dir | words carried
//   req     | in  | kind, data_in
//   rsp     | out | ok, data_out
//
// One word is accepted per cycle while no response is stalled; its response appears
// the next cycle from the response register, with consume data straight from the RAM
// read register. A stalled response holds req.ready low until rsp is taken.
// Reset clears all indexes and batch counts at once; slot contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module batched_spsc_ring_queue_top import brq_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int BATCH = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	brq_req_if.sink   req,
	brq_rsp_if.source rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              accept;
	brq_status_t       status;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [DATA_W-1:0] rdata;
	logic              valid_s1, ok_s1, rd_s1;

	assign req.ready = !valid_s1 || rsp.ready;
	assign accept    = req.valid && req.ready;

	brq_ctrl #(
		.DEPTH(DEPTH),
		.BATCH(BATCH),
		.AW   (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.kind     (req.kind),
		.status   (status),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr)
	);

	brq_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(req.data_in),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1 <= status.ok;
			rd_s1 <= status.rd;
		end
	end

	assign rsp.valid    = valid_s1;
	assign rsp.ok       = ok_s1;
	assign rsp.data_out = rd_s1 ? rdata : '0;

endmodule

`default_nettype wire
